[rtl/ttop_pkg.sv]
// Shared types, constants and helpers for the timer table.
`timescale 1ns / 1ps
`default_nettype none

package ttop_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int TIME_W = 48;
    localparam int INTV_W = 32;
    localparam int TAG_W  = 16;
    localparam int DIST_W = 32;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [TIME_W-1:0] DIST_MAX = TIME_W'(32'h7FFF_FFFF);

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        KIND_ADDED   = 3'd0,
        KIND_FULL    = 3'd1,
        KIND_FIRED   = 3'd2,
        KIND_NONE    = 3'd3,
        KIND_CLEARED = 3'd4,
        KIND_QUERY   = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIST,
        ST_REPORT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] due;
        logic [INTV_W-1:0] intv;
        logic [TAG_W-1:0]  tag;
        logic              rep;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

    // base + delta, clamped to the top of the time range
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] base,
                                                  input logic [INTV_W-1:0] delta);
        logic [TIME_W:0] sum;
        begin
            sum = {1'b0, base} + (TIME_W + 1)'(delta);
            sat_add = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

[rtl/timer_table_one_shot_periodic_unit.sv]
// Timer table top level: command decode, chain of timer cells, result register.
// Add, clear, query: scan rotates every timer once, then distance, then the result word.
// Tick: scan rotates every timer once, then distance, then a walk over the timers that
// emits one fired word per due timer (waits on res_stall), then idle; when nothing is due,
// report writes the result word instead. One command at a time, taken in idle.
// Reset clears the timer count and control; entry contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module timer_table_one_shot_periodic_unit import ttop_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire logic [1:0]         mode,
    input  wire logic [TIME_W-1:0]  now_ms,
    input  wire logic [INTV_W-1:0]  delay_ms,
    input  wire logic               periodic,
    input  wire logic [TAG_W-1:0]   task_id,

    output logic                    res_valid,
    input  wire logic               res_stall,
    output logic [2:0]              kind,
    output logic [TAG_W-1:0]        fired_task,
    output logic                    fired_periodic,
    output logic [CNT_W-1:0]        timer_count,
    output logic signed [DIST_W-1:0] time_until_next,
    output logic                    last
);

    state_t             state_reg, state_next;
    mode_t              mode_reg, mode_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    kind_t              rkind_reg, rkind_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]   fire_reg, fire_next;
    logic [CNT_W-1:0]   kept_reg, kept_next;
    logic [TIME_W-1:0]  min_reg, min_next;
    logic [DIST_W-1:0]  dist_reg, dist_next;

    logic               res_valid_reg, res_valid_next;
    kind_t              kind_reg, kind_next;
    logic [TAG_W-1:0]   task_reg, task_next;
    logic               per_reg, per_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [DIST_W-1:0]  tun_reg, tun_next;
    logic               last_reg, last_next;

    entry_t             cells [DEPTH];
    entry_t             head, head_new, add_entry, bcast;
    logic               head_fire, head_keep, is_tick, out_free;
    logic               shift_en, tail_load, add_load;
    logic [CNT_W-1:0]   tail_idx;
    logic [TIME_W-1:0]  diff;

    assign head     = cells[0];
    assign is_tick  = (mode_reg == MODE_TICK);
    assign out_free = !res_valid_reg || !res_stall;
    assign tail_idx = cnt_reg - CNT_W'(1);

    always_comb
    begin
        head_fire = is_tick && (head.due <= now_reg);
        head_keep = !head_fire || head.rep;
        head_new  = head;
        if (head_fire && head.rep)
        begin
            head_new.due = sat_add(now_reg, head.intv);
        end
    end

    always_comb
    begin
        add_entry.due  = sat_add(now_ms, delay_ms);
        add_entry.intv = delay_ms;
        add_entry.tag  = task_id;
        add_entry.rep  = periodic;
    end

    // scan rotates entries unchanged; emit writes back the rescheduled head
    assign bcast = (state_reg == ST_EMIT) ? head_new :
                   (state_reg == ST_SCAN) ? head : add_entry;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            cell_ctl_t ctl;
            entry_t    nbr;

            assign ctl.load  = (tail_load && (tail_idx == CNT_W'(gi))) ||
                               (add_load && (cnt_reg == CNT_W'(gi)));
            assign ctl.shift = shift_en && !ctl.load;

            if (gi == DEPTH - 1)
            begin : g_end
                assign nbr = cells[0];
            end
            else
            begin : g_mid
                assign nbr = cells[gi + 1];
            end

            ttop_cell u_cell (
                .clk   (clk),
                .ctl   (ctl),
                .nbr   (nbr),
                .bcast (bcast),
                .entry (cells[gi])
            );
        end
    endgenerate

    assign diff = min_reg - now_reg;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        now_next       = now_reg;
        rkind_next     = rkind_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        fire_next      = fire_reg;
        kept_next      = kept_reg;
        min_next       = min_reg;
        dist_next      = dist_reg;
        res_valid_next = res_valid_reg && res_stall;
        kind_next      = kind_reg;
        task_next      = task_reg;
        per_next       = per_reg;
        count_next     = count_reg;
        tun_next       = tun_reg;
        last_next      = last_reg;
        shift_en       = 1'b0;
        tail_load      = 1'b0;
        add_load       = 1'b0;
        cmd_stall      = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    mode_next = mode_t'(mode);
                    now_next  = now_ms;
                    fire_next = '0;
                    kept_next = '0;
                    min_next  = TIME_MAX;
                    unique case (mode_t'(mode))
                        MODE_ADD:
                        begin
                            if (cnt_reg < CNT_W'(DEPTH))
                            begin
                                add_load   = 1'b1;
                                cnt_next   = cnt_reg + CNT_W'(1);
                                rkind_next = KIND_ADDED;
                            end
                            else
                            begin
                                rkind_next = KIND_FULL;
                            end
                        end
                        MODE_TICK:  rkind_next = KIND_NONE;
                        MODE_CLEAR:
                        begin
                            cnt_next   = '0;
                            rkind_next = KIND_CLEARED;
                        end
                        default:    rkind_next = KIND_QUERY;
                    endcase
                    rem_next   = cnt_next;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (rem_reg == '0)
                begin
                    state_next = ST_DIST;
                end
                else
                begin
                    shift_en  = 1'b1;
                    tail_load = 1'b1;
                    rem_next  = rem_reg - CNT_W'(1);
                    if (head_fire)
                    begin
                        fire_next = fire_reg + CNT_W'(1);
                    end
                    if (head_keep)
                    begin
                        kept_next = kept_reg + CNT_W'(1);
                        if (head_new.due < min_reg)
                        begin
                            min_next = head_new.due;
                        end
                    end
                end
            end

            ST_DIST:
            begin
                if (kept_reg == '0)
                begin
                    dist_next = '1;
                end
                else if (min_reg <= now_reg)
                begin
                    dist_next = '0;
                end
                else if (diff > DIST_MAX)
                begin
                    dist_next = DIST_MAX[DIST_W-1:0];
                end
                else
                begin
                    dist_next = diff[DIST_W-1:0];
                end
                if (is_tick && (fire_reg != '0))
                begin
                    rem_next   = cnt_reg;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_REPORT;
                end
            end

            ST_REPORT:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    kind_next      = rkind_reg;
                    task_next      = '0;
                    per_next       = 1'b0;
                    count_next     = kept_reg;
                    tun_next       = dist_reg;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_EMIT:
            begin
                if (rem_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (!head_fire || out_free)
                begin
                    shift_en  = 1'b1;
                    tail_load = head_keep;
                    rem_next  = rem_reg - CNT_W'(1);
                    if (!head_keep)
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                    if (head_fire)
                    begin
                        res_valid_next = 1'b1;
                        kind_next      = KIND_FIRED;
                        task_next      = head.tag;
                        per_next       = head.rep;
                        count_next     = kept_reg;
                        tun_next       = dist_reg;
                        last_next      = (fire_reg == CNT_W'(1));
                        fire_next      = fire_reg - CNT_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            fire_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            fire_reg      <= fire_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        now_reg   <= now_next;
        rkind_reg <= rkind_next;
        kept_reg  <= kept_next;
        min_reg   <= min_next;
        dist_reg  <= dist_next;
        kind_reg  <= kind_next;
        task_reg  <= task_next;
        per_reg   <= per_next;
        count_reg <= count_next;
        tun_reg   <= tun_next;
        last_reg  <= last_next;
    end

    assign res_valid       = res_valid_reg;
    assign kind            = kind_reg;
    assign fired_task      = task_reg;
    assign fired_periodic  = per_reg;
    assign timer_count     = count_reg;
    assign time_until_next = tun_reg;
    assign last            = last_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("timer count above table depth");

    a_fire_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> fire_reg <= rem_reg)
        else $error("more fires pending than entries left to walk");

    a_nonfire_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind != KIND_FIRED |-> fired_task == '0 && !fired_periodic && last)
        else $error("non-fired word carries task data or is not last");

    a_empty_dist: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((timer_count == '0) == (time_until_next == -1)))
        else $error("distance and empty table disagree");

endmodule

`default_nettype wire

[rtl/ttop_cell.sv]
// One slot of the timer chain: takes its neighbor's entry or a broadcast entry.
`timescale 1ns / 1ps
`default_nettype none

module ttop_cell import ttop_pkg::*;
(
    input  wire logic      clk,
    input  wire cell_ctl_t ctl,
    input  wire entry_t    nbr,
    input  wire entry_t    bcast,
    output entry_t         entry
);

    entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            entry_reg <= bcast;
        end
        else if (ctl.shift)
        begin
            entry_reg <= nbr;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire
